@@ rtl/cvsd_pkg.sv @@
// ---------------------------------------------------------------------------
// cvsd_pkg: shared types and constants for the stereo CVSD codec
// Channel state record, state bank select, command codes and adaptation
// constants.
// ---------------------------------------------------------------------------
package cvsd_pkg;

  // Command carried in the request's tuser
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  // Per-channel codec state
  typedef struct packed {
    logic        [2:0]  history;
    logic signed [15:0] reference;
    logic        [15:0] step;
  } chan_state_t;

  // Which of the four state records a request works on
  typedef struct packed {
    logic dec;      // 0 encoder bank, 1 decoder bank
    logic channel;  // 0 left, 1 right
  } state_sel_t;

  localparam int unsigned       NUM_CHANNELS    = 2;
  localparam logic [15:0]       STEP_RESET      = 16'd1024;
  localparam logic [15:0]       STEP_SHRINK_MAX = 16'h03ff;
  localparam logic [15:0]       STEP_SAT        = 16'hffff;
  localparam logic [2:0]        HIST_ALL_ZERO   = 3'b000;
  localparam logic [2:0]        HIST_ALL_ONE    = 3'b111;
  localparam logic signed [15:0] REF_MAX        = 16'sh7fff;
  localparam logic signed [15:0] REF_MIN        = 16'sh8000;

endpackage

@@ rtl/cvsd_update.sv @@
// ---------------------------------------------------------------------------
// cvsd_update: one CVSD state update
// Shifts the bit into the history, adapts the step and moves the reference
// with saturation. Purely combinational.
// ---------------------------------------------------------------------------
module cvsd_update (
  input  cvsd_pkg::chan_state_t cur_state,
  input  logic                  bit_val,
  output cvsd_pkg::chan_state_t nxt_state
);

  logic [2:0]         hist_nxt;
  logic [16:0]        grown;
  logic [15:0]        shrunk;
  logic [15:0]        step_nxt;
  logic signed [17:0] ref_wide;
  logic signed [15:0] ref_nxt;

  always_comb begin
    hist_nxt = {cur_state.history[1:0], bit_val};

    // run of three: 2*step - step/4, saturating
    grown  = {cur_state.step, 1'b0} - {3'b000, cur_state.step[15:2]};
    shrunk = {1'b0, cur_state.step[15:1]} + {3'b000, cur_state.step[15:3]};

    if (hist_nxt inside {cvsd_pkg::HIST_ALL_ZERO, cvsd_pkg::HIST_ALL_ONE}) begin
      step_nxt = grown[16] ? cvsd_pkg::STEP_SAT : grown[15:0];
    end else if (cur_state.step > cvsd_pkg::STEP_SHRINK_MAX) begin
      step_nxt = shrunk;
    end else begin
      step_nxt = cur_state.step;
    end

    if (bit_val) begin
      ref_wide = {{2{cur_state.reference[15]}}, cur_state.reference}
                 + $signed({2'b00, step_nxt});
    end else begin
      ref_wide = {{2{cur_state.reference[15]}}, cur_state.reference}
                 - $signed({2'b00, step_nxt});
    end

    // fits in 16 bits when the top three bits agree
    if (ref_wide[17:15] == 3'b000 || ref_wide[17:15] == 3'b111) begin
      ref_nxt = ref_wide[15:0];
    end else if (ref_wide[17]) begin
      ref_nxt = cvsd_pkg::REF_MIN;
    end else begin
      ref_nxt = cvsd_pkg::REF_MAX;
    end

    nxt_state.history   = hist_nxt;
    nxt_state.step      = step_nxt;
    nxt_state.reference = ref_nxt;
  end

endmodule

@@ rtl/cvsd_bank.sv @@
// ---------------------------------------------------------------------------
// cvsd_bank: encoder and decoder state for both channels
// Four state records in flops, one combinational read and one write port
// sharing the same select.
// ---------------------------------------------------------------------------
module cvsd_bank (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cvsd_pkg::state_sel_t  sel,
  input  logic                  wr_en,
  input  cvsd_pkg::chan_state_t wr_state,
  output cvsd_pkg::chan_state_t rd_state
);

  cvsd_pkg::chan_state_t enc_r [cvsd_pkg::NUM_CHANNELS];
  cvsd_pkg::chan_state_t dec_r [cvsd_pkg::NUM_CHANNELS];
  cvsd_pkg::chan_state_t init_state;

  assign init_state = '{history:   cvsd_pkg::HIST_ALL_ZERO,
                        reference: 16'sd0,
                        step:      cvsd_pkg::STEP_RESET};

  assign rd_state = sel.dec ? dec_r[sel.channel] : enc_r[sel.channel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cvsd_pkg::NUM_CHANNELS; i++) begin
        enc_r[i] <= init_state;
        dec_r[i] <= init_state;
      end
    end else if (wr_en) begin
      if (sel.dec) begin
        dec_r[sel.channel] <= wr_state;
      end else begin
        enc_r[sel.channel] <= wr_state;
      end
    end
  end

  // step starts at 1024 and a shrink only applies above 1023 (x5/8),
  // so no step may fall below 640
  localparam logic [15:0] STEP_FLOOR = 16'd640;

  a_step_floor: assert property (@(posedge clk) disable iff (!rst_n)
    enc_r[0].step >= STEP_FLOOR && enc_r[1].step >= STEP_FLOOR &&
    dec_r[0].step >= STEP_FLOOR && dec_r[1].step >= STEP_FLOOR)
    else $error("codec step below floor");

  a_enc_isolate: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !sel.dec |=> dec_r[0] == $past(dec_r[0]) && dec_r[1] == $past(dec_r[1]))
    else $error("encoder write disturbed decoder state");

  a_chan_isolate: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !sel.channel |=> enc_r[1] == $past(enc_r[1]) && dec_r[1] == $past(dec_r[1]))
    else $error("left channel write disturbed right channel state");

endmodule

@@ rtl/cvsd_stereo_codec_top.sv @@
// ---------------------------------------------------------------------------
// cvsd_stereo_codec_top: two-channel CVSD encoder/decoder
// Input register, single-pass state update, output register.
// ---------------------------------------------------------------------------
// Each request either encodes one 16-bit PCM sample into one bit or decodes
// one bit into a 16-bit sample, on the left or right channel. Encoder and
// decoder keep separate state per channel (3-bit history, signed reference,
// step), all reset to history 0, reference 0, step 1024. Every request gives
// exactly one result: bit_out for an encode (sample_out is 0), sample_out
// for a decode (bit_out is 0). Throughput is one request per clock while
// results are taken. The request is held in the input register, and its
// update is loaded into the output register, raising out_tvalid, once the
// output slot is free or being emptied. The state is written at the same
// edge that loads the result, so consecutive requests on one channel see
// each other's updates without stalls. A full output register that is not
// taken holds the input register, and in_tready drops once both are full.
// ---------------------------------------------------------------------------
module cvsd_stereo_codec_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] sample_in, [16] bit_in, [23:17] zero
  input  logic [1:0]  in_tuser,   // [0] cmd, [1] channel

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] bit_out, [16:1] sample_out, [23:17] zero
);

  // input register
  logic               s1_valid_r;
  cvsd_pkg::cmd_t     s1_cmd_r;
  logic               s1_chan_r;
  logic signed [15:0] s1_sample_r;
  logic               s1_bit_r;

  // output register
  logic               out_valid_r;
  logic               out_bit_r;
  logic signed [15:0] out_sample_r;

  logic               advance;
  logic               upd_bit;
  logic               out_bit_nxt;
  logic signed [15:0] out_sample_nxt;

  cvsd_pkg::state_sel_t  sel;
  cvsd_pkg::chan_state_t cur_state;
  cvsd_pkg::chan_state_t nxt_state;

  // the held request moves on when the output slot is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= cvsd_pkg::cmd_t'(in_tuser[0]);
      s1_chan_r   <= in_tuser[1];
      s1_sample_r <= in_tdata[15:0];
      s1_bit_r    <= in_tdata[16];
    end
  end

  assign sel.dec     = (s1_cmd_r == cvsd_pkg::CMD_DECODE);
  assign sel.channel = s1_chan_r;

  cvsd_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .sel      (sel),
    .wr_en    (advance),
    .wr_state (nxt_state),
    .rd_state (cur_state)
  );

  // encoder decision: 1 when the sample is at or above the reference
  always_comb begin
    case (s1_cmd_r)
      cvsd_pkg::CMD_ENCODE: begin
        upd_bit        = (s1_sample_r >= cur_state.reference);
        out_bit_nxt    = upd_bit;
        out_sample_nxt = 16'sd0;
      end
      cvsd_pkg::CMD_DECODE: begin
        upd_bit        = s1_bit_r;
        out_bit_nxt    = 1'b0;
        out_sample_nxt = nxt_state.reference;
      end
      default: begin
        upd_bit        = 1'b0;
        out_bit_nxt    = 1'b0;
        out_sample_nxt = 16'sd0;
      end
    endcase
  end

  cvsd_update u_update (
    .cur_state (cur_state),
    .bit_val   (upd_bit),
    .nxt_state (nxt_state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bit_r    <= out_bit_nxt;
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_sample_r, out_bit_r};

  // a result appears only when a held request was moved into the output slot
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without a request");

  // a stalled result keeps the input register occupied
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r)
    else $error("request dropped while output stalled");

  // an encode result carries a zero sample field
  a_enc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == cvsd_pkg::CMD_ENCODE |=> out_sample_r == 16'sd0)
    else $error("encode result has nonzero sample");

  // a decode result carries a zero bit field
  a_dec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == cvsd_pkg::CMD_DECODE |=> !out_bit_r)
    else $error("decode result has nonzero bit");

endmodule

@@ verif/tb_cvsd_stereo_codec_top.sv @@
// ---------------------------------------------------------------------------
// tb_cvsd_stereo_codec_top: self-checking bench for the stereo CVSD codec
// Directed corner requests, then random runs of encode and decode requests.
// A request-level predictor keeps its own copy of the encoder and decoder
// state. Each result is checked against the oldest predicted one. Both
// stream sides idle at random, and one long receiver hold-off backs up
// the input.
// ---------------------------------------------------------------------------
module tb_cvsd_stereo_codec_top;

  localparam int unsigned N_RANDOM    = 1650;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned HOLD_LEN    = 400;   // long receiver hold-off, cycles
  localparam int unsigned HOLD_AFTER  = 300;   // starts after this many requests
  localparam int unsigned TAIL_CYCLES = 8;     // extra clocks after the last result

  // One codec request as the bench sees it
  typedef struct {
    cvsd_pkg::cmd_t     cmd;
    logic               channel;
    logic signed [15:0] sample;
    logic               bit_in;
  } codec_req_t;

  // One predicted result
  typedef struct {
    logic               bit_out;
    logic signed [15:0] sample_out;
  } codec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [15:0] sample_in, [16] bit_in, [23:17] zero
  logic [1:0]  in_tuser = '0;   // [0] cmd, [1] channel

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [0] bit_out, [16:1] sample_out, [23:17] zero

  cvsd_stereo_codec_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to be offered, and results predicted but not yet seen
  codec_req_t  pending_reqs[$];
  codec_res_t  expected_results[$];

  // Predictor state, indexed [bank][channel]; bank is the command itself
  cvsd_pkg::chan_state_t codec_state [2][2];

  int unsigned errors = 0;
  int unsigned reqs_accepted = 0;
  int unsigned cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor: applies one accepted request to the bench copy of the state
  // and queues the result it must produce.
  // -------------------------------------------------------------------------
  function automatic void predict_codec(input codec_req_t r);
    cvsd_pkg::chan_state_t s;
    logic        b;
    int unsigned stp;
    int unsigned grown;
    int          ref_next;
    codec_res_t  e;
    s = codec_state[r.cmd][r.channel];
    // encoder decides the bit itself, decoder takes it from the request
    if (r.cmd == cvsd_pkg::CMD_ENCODE) begin
      b = ($signed(r.sample) >= $signed(s.reference));
    end else begin
      b = r.bit_in;
    end
    s.history = {s.history[1:0], b};
    stp = 32'(s.step);
    if (s.history == cvsd_pkg::HIST_ALL_ZERO || s.history == cvsd_pkg::HIST_ALL_ONE) begin
      // run of three equal bits: grow by 7/4, clip at full scale
      grown = (stp << 1) - (stp >> 2);
      stp = (grown > 32'(cvsd_pkg::STEP_SAT)) ? 32'(cvsd_pkg::STEP_SAT) : grown;
    end else if (stp > 32'(cvsd_pkg::STEP_SHRINK_MAX)) begin
      stp = (stp >> 1) + (stp >> 3);
    end
    ref_next = b ? int'($signed(s.reference)) + int'(stp)
                 : int'($signed(s.reference)) - int'(stp);
    if (ref_next > int'(cvsd_pkg::REF_MAX)) ref_next = int'(cvsd_pkg::REF_MAX);
    if (ref_next < int'(cvsd_pkg::REF_MIN)) ref_next = int'(cvsd_pkg::REF_MIN);
    s.step      = stp[15:0];
    s.reference = ref_next[15:0];
    codec_state[r.cmd][r.channel] = s;
    // unused result field reads as zero
    e.bit_out    = (r.cmd == cvsd_pkg::CMD_ENCODE) ? b : 1'b0;
    e.sample_out = (r.cmd == cvsd_pkg::CMD_DECODE) ? s.reference : 16'sd0;
    expected_results.push_back(e);
  endfunction

  function automatic void queue_req(input cvsd_pkg::cmd_t cmd, input logic ch,
                                    input logic [15:0] smp, input logic bt);
    codec_req_t r;
    r.cmd     = cmd;
    r.channel = ch;
    r.sample  = smp;
    r.bit_in  = bt;
    pending_reqs.push_back(r);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned draw_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers queued requests, idles between them at random.
  // -------------------------------------------------------------------------
  int unsigned drv_gap = 0;
  int unsigned drv_burst = 0;

  always @(posedge clk) begin : driver
    int unsigned g;
    codec_req_t  r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        r.cmd     = cvsd_pkg::cmd_t'(in_tuser[0]);
        r.channel = in_tuser[1];
        r.sample  = in_tdata[15:0];
        r.bit_in  = in_tdata[16];
        predict_codec(r);
        reqs_accepted <= reqs_accepted + 1;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_tvalid || in_tready) begin
        if (drv_gap != 0) begin
          drv_gap   <= drv_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          r = pending_reqs.pop_front();
          in_tdata  <= {7'b0, r.bit_in, r.sample};
          in_tuser  <= {r.channel, r.cmd};
          in_tvalid <= 1'b1;
          // stretches of back-to-back requests now and then
          if (drv_burst != 0) begin
            drv_burst <= drv_burst - 1;
            g = 0;
          end else begin
            if ($urandom_range(0, 39) == 0) drv_burst <= $urandom_range(20, 80);
            g = draw_gap();
          end
          drv_gap <= g;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Long hold-off: once, the receiver stops taking results until hold_cnt
  // reaches HOLD_LEN while the driver keeps offering, so the pipe fills and
  // in_tready drops.
  // -------------------------------------------------------------------------
  logic        hold_on = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt = 0;

  always @(posedge clk) begin
    if (rst_n && !hold_done && reqs_accepted >= HOLD_AFTER) begin
      if (hold_cnt == HOLD_LEN) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_on  <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction and
  // stalls out_tready at random.
  // -------------------------------------------------------------------------
  int unsigned mon_stall = 0;
  int unsigned mon_burst = 0;

  always @(posedge clk) begin : monitor
    codec_res_t  e;
    int unsigned g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, got tdata=%h", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_tdata[0] !== e.bit_out || out_tdata[16:1] !== e.sample_out ||
              out_tdata[23:17] !== 7'b0) begin
            $display({"%0t: mismatch expected bit_out=%0d sample_out=%0d pad=0, ",
                      "got bit_out=%0d sample_out=%0d pad=%h"},
                     $time, e.bit_out, e.sample_out, out_tdata[0],
                     $signed(out_tdata[16:1]), out_tdata[23:17]);
            errors <= errors + 1;
          end
        end
      end
      if (hold_on) begin
        out_tready <= 1'b0;
      end else if (mon_stall != 0) begin
        mon_stall  <= mon_stall - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        if (mon_burst != 0) begin
          mon_burst <= mon_burst - 1;
          g = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) mon_burst <= $urandom_range(20, 80);
          g = draw_gap();
        end
        if (g != 0) begin
          mon_stall  <= g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned        n_gen;
    int unsigned        kind;
    int unsigned        run;
    cvsd_pkg::cmd_t     cmd;
    logic               ch;
    logic [15:0]        hold_val;
    logic               hold_bit;
    logic [15:0]        smp;
    logic               bt;

    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < 2; c++) begin
        codec_state[b][c].history   = '0;
        codec_state[b][c].reference = '0;
        codec_state[b][c].step      = cvsd_pkg::STEP_RESET;
      end
    end

    // zero bit straight after reset counts as a run of three equal bits;
    // sample_in is ignored on decode
    queue_req(cvsd_pkg::CMD_DECODE, 1'b0, 16'h8000, 1'b0);
    queue_req(cvsd_pkg::CMD_DECODE, 1'b0, 16'hffff, 1'b0);
    queue_req(cvsd_pkg::CMD_DECODE, 1'b0, 16'h7fff, 1'b0);
    // long run of ones: step growth clips at full scale, reference at max
    for (int i = 0; i < 16; i++)
      queue_req(cvsd_pkg::CMD_DECODE, 1'b1, 16'($urandom), 1'b1);
    // encode at positive full scale; bit_in is ignored on encode
    for (int i = 0; i < 6; i++) queue_req(cvsd_pkg::CMD_ENCODE, 1'b0, 16'h7fff, 1'b1);
    // sample equal to reference gives a one
    queue_req(cvsd_pkg::CMD_ENCODE, 1'b1, 16'h0000, 1'b1);
    // encode at negative full scale: reference clips at min
    for (int i = 0; i < 12; i++) queue_req(cvsd_pkg::CMD_ENCODE, 1'b1, 16'h8000, 1'b1);

    // Random part: runs on one channel and bank with a shaped pattern, so
    // steps climb to saturation, shrink on alternation, or wander.
    n_gen = 0;
    while (n_gen < N_RANDOM) begin
      kind     = $urandom_range(0, 9);
      cmd      = cvsd_pkg::cmd_t'($urandom_range(0, 1));
      ch       = 1'($urandom_range(0, 1));
      run      = $urandom_range(1, 16);
      hold_val = 16'($urandom);
      hold_bit = 1'($urandom_range(0, 1));
      for (int i = 0; i < run; i++) begin
        smp = 16'($urandom);
        bt  = 1'($urandom_range(0, 1));
        if (cmd == cvsd_pkg::CMD_ENCODE) begin
          case (kind)
            4, 5: smp = hold_val;
            6:    smp = i[0] ? 16'h7fff : 16'h8000;
            7:    smp = 16'($urandom_range(0, 4095)) - 16'd2048;
            8:    smp = hold_bit ? 16'h7fff : 16'h8000;
            9:    smp = hold_val + 16'(i * 500);
            default: ;
          endcase
        end else begin
          case (kind)
            4, 5, 6: bt = hold_bit;
            7:       bt = i[0];
            8, 9:    bt = i[1] ^ hold_bit;
            default: ;
          endcase
        end
        queue_req(cmd, ch, smp, bt);
        n_gen++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
